@@ design/pscc_pkg.sv @@
// Package for the path segment safety checker.
// Holds the segment state type, the prefix text and the byte and stem tests.
// No dependencies.
package pscc_pkg;

  localparam logic [2:0] PREFIX_LEN = 3'd7;
  localparam logic [1:0] SEG_LEN_MAX = 2'd3;
  localparam logic [2:0] STEM_MAX = 3'd4;
  localparam logic [2:0] STEM_OVER = 3'd5;

  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_DOT = 8'h2e;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7a;
  localparam logic [7:0] CASE_OFS = 8'h20;
  localparam logic [7:0] CH_ONE = 8'h31;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef struct packed {
    logic [1:0]      seg_len;
    logic            all_dots;
    logic [7:0]      prev;
    logic [3:0][7:0] stem;
    logic [2:0]      stem_len;
    logic            stem_closed;
  } seg_t;

  localparam seg_t SEG_RESET = '{
    seg_len: 2'd0, all_dots: 1'b1, prev: 8'h00, stem: '0,
    stem_len: 3'd0, stem_closed: 1'b0
  };

  // expected byte of "Assets/" at a given position
  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0: c = "A";
      3'd1: c = "s";
      3'd2: c = "s";
      3'd3: c = "e";
      3'd4: c = "t";
      3'd5: c = "s";
      3'd6: c = "/";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_bad_byte(input logic [7:0] b);
    return (b < CH_SPACE) ||
           (b inside {8'h5c, 8'h3a, 8'h2a, 8'h3f, 8'h22, 8'h3c, 8'h3e, 8'h7c});
  endfunction

  function automatic logic stem_is(input seg_t s, input logic [23:0] txt);
    return s.stem[0] == txt[23:16] && s.stem[1] == txt[15:8] && s.stem[2] == txt[7:0];
  endfunction

  function automatic logic stem_is_device(input seg_t s);
    logic dev;
    dev = 1'b0;
    if (s.stem_len == 3'd3) begin
      dev = stem_is(s, "CON") || stem_is(s, "PRN") ||
            stem_is(s, "AUX") || stem_is(s, "NUL");
    end else if (s.stem_len == STEM_MAX) begin
      dev = (stem_is(s, "COM") || stem_is(s, "LPT")) &&
            s.stem[3] >= CH_ONE && s.stem[3] <= CH_NINE;
    end
    return dev;
  endfunction

  // closing a segment: does it break a rule
  function automatic logic seg_fails(input seg_t s);
    logic f;
    if (s.seg_len == 2'd0) begin
      f = 1'b1;
    end else begin
      f = (s.all_dots && s.seg_len <= 2'd2) ||
          s.prev == CH_DOT || s.prev == CH_SPACE || stem_is_device(s);
    end
    return f;
  endfunction

endpackage

@@ design/pscc_in_if.sv @@
// Input channel of the path segment safety checker: one path byte per word.
// Depends on nothing.
interface pscc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] path_byte;
  logic       final_byte;

  modport source(output valid, output path_byte, output final_byte, input ready);
  modport sink(input valid, input path_byte, input final_byte, output ready);
endinterface

@@ design/pscc_out_if.sv @@
// Result channel of the path segment safety checker: one verdict per word.
// Depends on nothing.
interface pscc_out_if;
  logic valid;
  logic ready;
  logic path_safe;

  modport source(output valid, output path_safe, input ready);
  modport sink(input valid, input path_safe, output ready);
endinterface

@@ design/pscc_rule_core.sv @@
// Rule state of the path checker: prefix match, fail flag, current segment.
// Updates on each stepped byte and gives the verdict on a final byte.
// Depends on pscc_pkg.
module pscc_rule_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] byte_in,
  input  logic       last_in,
  output logic       verdict
);

  logic [2:0]    pp_r, pp_nxt;
  logic          fail_r, fail_nxt;
  pscc_pkg::seg_t seg_r, seg_nxt;

  always_comb begin
    pscc_pkg::seg_t s;
    logic [2:0] pp;
    logic       f;
    logic [7:0] up;
    s  = seg_r;
    pp = pp_r;
    f  = fail_r;
    up = byte_in;

    if (pp < pscc_pkg::PREFIX_LEN) begin
      if (byte_in == pscc_pkg::prefix_char(pp)) begin
        pp = pp + 3'd1;
      end else begin
        f = 1'b1;
      end
    end

    if (byte_in == pscc_pkg::CH_SLASH) begin
      f = f | pscc_pkg::seg_fails(s);
      s = pscc_pkg::SEG_RESET;
    end else begin
      if (s.seg_len < pscc_pkg::SEG_LEN_MAX) s.seg_len = s.seg_len + 2'd1;
      if (byte_in != pscc_pkg::CH_DOT) s.all_dots = 1'b0;
      f = f | pscc_pkg::is_bad_byte(byte_in);
      if (!s.stem_closed) begin
        if (byte_in == pscc_pkg::CH_DOT) begin
          s.stem_closed = 1'b1;
        end else begin
          if (byte_in >= pscc_pkg::CH_LOW_A && byte_in <= pscc_pkg::CH_LOW_Z) begin
            up = byte_in - pscc_pkg::CASE_OFS;
          end
          if (s.stem_len < pscc_pkg::STEM_MAX) s.stem[s.stem_len[1:0]] = up;
          if (s.stem_len < pscc_pkg::STEM_OVER) s.stem_len = s.stem_len + 3'd1;
        end
      end
      s.prev = byte_in;
    end

    verdict = !(f | pscc_pkg::seg_fails(s)) && pp == pscc_pkg::PREFIX_LEN;

    if (last_in) begin
      pp_nxt   = 3'd0;
      fail_nxt = 1'b0;
      seg_nxt  = pscc_pkg::SEG_RESET;
    end else begin
      pp_nxt   = pp;
      fail_nxt = f;
      seg_nxt  = s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_r   <= 3'd0;
      fail_r <= 1'b0;
      seg_r  <= pscc_pkg::SEG_RESET;
    end else if (step) begin
      pp_r   <= pp_nxt;
      fail_r <= fail_nxt;
      seg_r  <= seg_nxt;
    end
  end

endmodule

@@ design/path_segment_safety_check.sv @@
// Path segment safety checker: takes a relative path one byte per word and
// gives one safe/unsafe verdict word per path. The final byte is held in the
// input register and its verdict in the output register. One byte is taken
// every cycle, as the rule state steps from the input register. A byte waits
// only when it is a final byte and the previous verdict has not been taken.
// Depends on pscc_pkg, pscc_in_if, pscc_out_if and pscc_rule_core.
module path_segment_safety_check (
  input  logic              clk,
  input  logic              rst_n,
  pscc_in_if.sink           in_ch,
  pscc_out_if.source        out_ch
);

  logic       in_vld_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       out_vld_r;
  logic       safe_r;
  logic       out_free;
  logic       advance;
  logic       verdict;

  assign out_free = !out_vld_r || out_ch.ready;
  assign advance  = in_vld_r && (!last_r || out_free);
  assign in_ch.ready = !in_vld_r || advance;

  pscc_rule_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .byte_in (byte_r),
    .last_in (last_r),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.path_byte;
      last_r <= in_ch.final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last_r) begin
      safe_r <= verdict;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.path_safe = safe_r;

`ifndef SYNTHESIS
  a_verdict_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    advance && last_r |=> out_vld_r)
    else $error("verdict not presented after final byte");

  a_final_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && last_r && !out_free |=> in_vld_r && last_r && $stable(byte_r))
    else $error("stalled final byte lost");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> in_vld_r && last_r && out_vld_r && !out_ch.ready)
    else $error("input stalled without a blocked verdict");
`endif

endmodule
